// File: rtl/core/sfd_pkg.sv
package sfd_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] SYNC_ALT_BYTE = 8'hFE;
    localparam logic [7:0] CKSUM_BASE    = 8'hFF;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_LEN_ERR = 2'd2,
        KIND_MSG_ERR = 2'd3
    } sfd_kind_t;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_LEN_L   = 9'b000000100,
        PH_LEN_H   = 9'b000001000,
        PH_LEN_CHK = 9'b000010000,
        PH_TOP_L   = 9'b000100000,
        PH_TOP_H   = 9'b001000000,
        PH_PAYLOAD = 9'b010000000,
        PH_MSG_CHK = 9'b100000000
    } sfd_phase_t;

    typedef struct packed {
        logic       valid;
        sfd_kind_t  kind;
        logic [7:0] data_byte;
        logic [15:0] topic;
        logic       frame_last;
    } sfd_result_t;

endpackage

// File: rtl/core/sfd_parser.sv
module sfd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    output sfd_pkg::sfd_result_t res
);
    import sfd_pkg::*;

    sfd_phase_t  phase_reg, phase_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [7:0]  topic_low_reg, topic_low_next;
    logic [15:0] topic_word_reg, topic_word_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  len_sum;
    logic [15:0] bytes_inc;

    assign len_sum   = frame_length_reg[7:0] + frame_length_reg[15:8];
    assign bytes_inc = bytes_seen_reg + 16'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        length_low_next   = length_low_reg;
        frame_length_next = frame_length_reg;
        topic_low_next    = topic_low_reg;
        topic_word_next   = topic_word_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_sum_next  = running_sum_reg;
        res               = '0;
        res.kind          = KIND_DATA;
        case (phase_reg)
            PH_SYNC2:
            begin
                phase_next = (in_byte == SYNC_ALT_BYTE || in_byte == SYNC_BYTE) ?
                             PH_LEN_L : PH_SYNC1;
            end
            PH_LEN_L:
            begin
                length_low_next = in_byte;
                phase_next      = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                frame_length_next = {in_byte, length_low_reg};
                phase_next        = PH_LEN_CHK;
            end
            PH_LEN_CHK:
            begin
                if (in_byte != (CKSUM_BASE - len_sum))
                begin
                    phase_next     = PH_SYNC1;
                    res.valid      = 1'b1;
                    res.kind       = KIND_LEN_ERR;
                    res.frame_last = 1'b1;
                end
                else
                begin
                    phase_next = PH_TOP_L;
                end
            end
            PH_TOP_L:
            begin
                topic_low_next   = in_byte;
                running_sum_next = in_byte;
                phase_next       = PH_TOP_H;
            end
            PH_TOP_H:
            begin
                topic_word_next  = {in_byte, topic_low_reg};
                running_sum_next = running_sum_reg + in_byte;
                bytes_seen_next  = '0;
                phase_next       = (frame_length_reg == '0) ? PH_MSG_CHK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                running_sum_next = running_sum_reg + in_byte;
                bytes_seen_next  = bytes_inc;
                if (bytes_inc >= frame_length_reg)
                begin
                    phase_next = PH_MSG_CHK;
                end
                res.valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = in_byte;
                res.topic     = topic_word_reg;
            end
            PH_MSG_CHK:
            begin
                phase_next     = PH_SYNC1;
                res.valid      = 1'b1;
                res.kind       = (in_byte != (CKSUM_BASE - running_sum_reg)) ?
                                 KIND_MSG_ERR : KIND_GOOD;
                res.topic      = topic_word_reg;
                res.frame_last = 1'b1;
            end
            default:
            begin
                // first sync, and any unexpected code
                phase_next = (in_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            length_low_reg   <= '0;
            frame_length_reg <= '0;
            topic_low_reg    <= '0;
            topic_word_reg   <= '0;
            bytes_seen_reg   <= '0;
            running_sum_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            length_low_reg   <= length_low_next;
            frame_length_reg <= frame_length_next;
            topic_low_reg    <= topic_low_next;
            topic_word_reg   <= topic_word_next;
            bytes_seen_reg   <= bytes_seen_next;
            running_sum_reg  <= running_sum_next;
        end
    end

endmodule

// File: rtl/core/sfd_out_reg.sv
module sfd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sfd_pkg::sfd_result_t res,
    input  logic                take,
    output logic                busy,
    output logic                out_valid,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_data,
    output logic [15:0]         out_topic,
    output logic                out_last
);
    import sfd_pkg::*;

    logic        valid_reg, valid_next;
    sfd_kind_t   kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] topic_reg;
    logic        last_reg;

    // a load replaces the held item, which is either empty or being taken
    assign valid_next = load ? res.valid : (valid_reg && !take);
    assign busy       = valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            kind_reg  <= res.kind;
            data_reg  <= res.data_byte;
            topic_reg <= res.topic;
            last_reg  <= res.frame_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    assign out_topic = topic_reg;
    assign out_last  = last_reg;

endmodule

// File: rtl/core/serial_frame_deframer.sv
// Serial frame deframer: takes one received byte per item on the slave side
// and finds frames of the form sync 0xFF, second sync 0xFE or 0xFF, 16-bit
// little-endian length, length checksum, 16-bit little-endian topic, payload
// and message checksum (each checksum is 0xFF minus the byte sum modulo 256).
// Payload bytes leave as they arrive, kind 0, tagged with the topic; every
// frame whose length checksum is checked ends with one status item (kind 1
// good, 2 length checksum error with topic zero, 3 message checksum error)
// carrying tlast. A bad second sync drops back to the hunt silently.
// Throughput is one byte per clock while the master side takes results:
// the parser state updates in a single pass between the input register
// and the result register. An accepted byte waits in the input register
// until the result slot is free; its result item is offered from that slot.
module serial_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] topic
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // frame_last
);
    import sfd_pkg::*;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        out_busy;
    logic        take;
    logic [7:0]  out_data;
    logic [15:0] out_topic;
    sfd_result_t res;

    assign take    = m_axis_tvalid && m_axis_tready;
    // the held byte is parsed once the result slot is free or being emptied
    assign advance = in_valid_reg && !out_busy;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .res     (res)
    );

    sfd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (res),
        .take      (take),
        .busy      (out_busy),
        .out_valid (m_axis_tvalid),
        .out_kind  (m_axis_tuser),
        .out_data  (out_data),
        .out_topic (out_topic),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_topic, out_data};

endmodule

// File: verif/serial_frame_deframer_test.sv
`timescale 1ns / 1ps

module serial_frame_deframer_test;

    import sfd_pkg::*;

    // one expected result item, as it should leave the master side
    typedef struct {
        sfd_kind_t   kind;
        logic [7:0]  data;
        logic [15:0] topic;
        logic        last;
    } deframed_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state, a private copy of the parser
    sfd_phase_t  st_phase;
    logic [7:0]  st_len_lo;
    logic [15:0] st_len;
    logic [7:0]  st_topic_lo;
    logic [15:0] st_topic;
    logic [15:0] st_count;
    logic [7:0]  st_sum;

    deframed_item_t pending_results[$];

    // idling controls shared by the sender, the receiver and the tests
    bit tx_gap_on;
    bit rx_stall_on;
    int hold_req;

    int fail_count;
    int bytes_parsed;
    int seen_payload;
    int seen_good;
    int seen_len_err;
    int seen_msg_err;

    serial_frame_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (fail_count < 40)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got,
                     want);
        fail_count++;
    endtask

    // works out what one accepted byte produces and queues it
    function void deframe_byte(input logic [7:0] b);
        deframed_item_t r;
        logic [7:0] want_ck;
        if (!(st_phase == PH_SYNC1 && b != SYNC_BYTE))
            bytes_parsed++;
        case (st_phase)
            PH_SYNC2:
                st_phase = (b == SYNC_ALT_BYTE || b == SYNC_BYTE) ? PH_LEN_L : PH_SYNC1;
            PH_LEN_L:
            begin
                st_len_lo = b;
                st_phase = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                st_len = {b, st_len_lo};
                st_phase = PH_LEN_CHK;
            end
            PH_LEN_CHK:
            begin
                want_ck = CKSUM_BASE - st_len[7:0] - st_len[15:8];
                if (b != want_ck)
                begin
                    // length checksum error: topic not read yet, so it reports zero
                    r.kind = KIND_LEN_ERR;
                    r.data = 8'h00;
                    r.topic = 16'h0000;
                    r.last = 1'b1;
                    pending_results.insert(pending_results.size(), r);
                    st_phase = PH_SYNC1;
                end
                else
                    st_phase = PH_TOP_L;
            end
            PH_TOP_L:
            begin
                st_topic_lo = b;
                st_sum = b;
                st_phase = PH_TOP_H;
            end
            PH_TOP_H:
            begin
                st_topic = {b, st_topic_lo};
                st_sum = st_sum + b;
                st_count = 16'h0000;
                // zero length skips straight to the message checksum
                st_phase = (st_len == 16'h0000) ? PH_MSG_CHK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                st_sum = st_sum + b;
                st_count = st_count + 16'h0001;
                if (st_count >= st_len)
                    st_phase = PH_MSG_CHK;
                r.kind = KIND_DATA;
                r.data = b;
                r.topic = st_topic;
                r.last = 1'b0;
                pending_results.insert(pending_results.size(), r);
            end
            PH_MSG_CHK:
            begin
                want_ck = CKSUM_BASE - st_sum;
                r.kind = (b != want_ck) ? KIND_MSG_ERR : KIND_GOOD;
                r.data = 8'h00;
                r.topic = st_topic;
                r.last = 1'b1;
                pending_results.insert(pending_results.size(), r);
                st_phase = PH_SYNC1;
            end
            default:
                st_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        endcase
    endfunction

    // offers one byte, after a random gap when gaps are on, and returns once it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, 6) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        deframe_byte(b);
    endtask

    // builds a frame and sends its first cut bytes, all of it when cut is zero
    task automatic send_frame(input logic [7:0] sync2, input logic [15:0] len,
                              input logic [15:0] topic, input bit bad_len,
                              input bit bad_msg, input int cut);
        logic [7:0] fb[$];
        logic [7:0] len_ck;
        logic [7:0] msg_sum;
        logic [7:0] pb;
        int i;
        len_ck = CKSUM_BASE - len[7:0] - len[15:8];
        if (bad_len)
            len_ck = len_ck ^ 8'($urandom_range(1, 255));
        msg_sum = topic[7:0] + topic[15:8];
        fb.insert(fb.size(), SYNC_BYTE);
        fb.insert(fb.size(), sync2);
        fb.insert(fb.size(), len[7:0]);
        fb.insert(fb.size(), len[15:8]);
        fb.insert(fb.size(), len_ck);
        fb.insert(fb.size(), topic[7:0]);
        fb.insert(fb.size(), topic[15:8]);
        for (i = 0; i < len; i++)
        begin
            pb = 8'($urandom);
            msg_sum = msg_sum + pb;
            fb.insert(fb.size(), pb);
        end
        if (bad_msg)
            fb.insert(fb.size(), (CKSUM_BASE - msg_sum) ^ 8'($urandom_range(1, 255)));
        else
            fb.insert(fb.size(), CKSUM_BASE - msg_sum);
        for (i = 0; i < fb.size() && (cut == 0 || i < cut); i++)
            send_byte(fb[i]);
    endtask

    // feeds filler until the parser is hunting for a sync again
    task automatic resync();
        while (st_phase != PH_SYNC1)
        begin
            if (st_phase == PH_LEN_CHK)
                send_byte(~(CKSUM_BASE - st_len[7:0] - st_len[15:8]));
            else
                send_byte(8'h00);
        end
    endtask

    // sender pauses until every expected result is back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (6)
            @(posedge clk);
    endtask

    task automatic random_frame();
        logic [15:0] len;
        int pick;
        pick = $urandom_range(0, 39);
        if (pick < 4)
            len = 16'h0000;
        else if (pick == 39)
            len = 16'($urandom_range(256, 300));
        else
            len = 16'($urandom_range(1, 16));
        send_frame($urandom_range(0, 1) ? SYNC_BYTE : SYNC_ALT_BYTE, len, 16'($urandom),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0, 0);
    endtask

    // extremes of the fields and each special case, one after another
    task automatic test_directed();
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        // zero-length frame on the alternate sync, all-ones topic
        send_frame(SYNC_ALT_BYTE, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 0);
        // bad second sync drops back silently
        send_byte(SYNC_BYTE);
        send_byte(8'h00);
        // all-ones length with a wrong length checksum
        send_frame(SYNC_BYTE, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 5);
        // one payload byte and a wrong message checksum, zero topic
        send_frame(SYNC_BYTE, 16'h0001, 16'h0000, 1'b0, 1'b1, 0);
        drain();
    endtask

    // mostly well-formed frames with random content and occasional bad checksums
    task automatic test_random_frames(input int target);
        int stop_at;
        stop_at = bytes_parsed + target;
        while (bytes_parsed < stop_at)
        begin
            // some frames run with no idling on one or both sides
            tx_gap_on = $urandom_range(0, 3) != 0;
            rx_stall_on = $urandom_range(0, 3) != 0;
            random_frame();
        end
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        drain();
    endtask

    // noise, cut-off frames and broken syncs between good frames
    task automatic test_noise_and_broken(input int target);
        int stop_at;
        int n;
        logic [7:0] b;
        stop_at = bytes_parsed + target;
        while (bytes_parsed < stop_at)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                    begin
                        b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom);
                        // keep noise from opening a long bogus frame
                        if (st_phase == PH_LEN_CHK)
                            b = ~(CKSUM_BASE - st_len[7:0] - st_len[15:8]);
                        send_byte(b);
                    end
                end
                1:
                    send_frame(SYNC_BYTE, 16'($urandom_range(0, 12)), 16'($urandom), 1'b0,
                               1'b0, $urandom_range(1, 10));
                2:
                begin
                    send_byte(SYNC_BYTE);
                    send_byte(8'($urandom_range(0, 253)));
                end
                default:
                    random_frame();
            endcase
            resync();
            random_frame();
        end
        drain();
    endtask

    // receiver holds off for a long stretch while frames keep coming
    task automatic test_backpressure(input int target);
        int stop_at;
        stop_at = bytes_parsed + target;
        tx_gap_on = 1'b0;
        hold_req = 150;
        while (bytes_parsed < stop_at)
            send_frame(SYNC_BYTE, 16'($urandom_range(4, 20)), 16'($urandom), 1'b0,
                       $urandom_range(0, 5) == 0, 0);
        tx_gap_on = 1'b1;
        drain();
    endtask

    // back to back on both sides
    task automatic test_burst(input int target);
        int stop_at;
        stop_at = bytes_parsed + target;
        tx_gap_on = 1'b0;
        rx_stall_on = 1'b0;
        while (bytes_parsed < stop_at)
            random_frame();
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        drain();
    endtask

    // receiver: random stalls per item plus the long hold-off on request
    initial
    begin
        int stall;
        int held;
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                for (held = 0; held < n; held++)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            stall = rx_stall_on ? $urandom_range(0, 6) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // result checker, compares each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        deframed_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none expected, kind", 16'(m_axis_tuser), 16'h0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", 16'(m_axis_tuser), 16'(want.kind));
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch("data_byte", 16'(m_axis_tdata[7:0]), 16'(want.data));
                if (m_axis_tdata[23:8] !== want.topic)
                    report_mismatch("topic", m_axis_tdata[23:8], want.topic);
                if (m_axis_tlast !== want.last)
                    report_mismatch("frame_last", 16'(m_axis_tlast), 16'(want.last));
                case (want.kind)
                    KIND_DATA:    seen_payload++;
                    KIND_GOOD:    seen_good++;
                    KIND_LEN_ERR: seen_len_err++;
                    default:      seen_msg_err++;
                endcase
            end
        end
    end

    // run limit, well beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("serial_frame_deframer_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        hold_req = 0;
        fail_count = 0;
        bytes_parsed = 0;
        seen_payload = 0;
        seen_good = 0;
        seen_len_err = 0;
        seen_msg_err = 0;
        st_phase = PH_SYNC1;
        st_len_lo = 8'h00;
        st_len = 16'h0000;
        st_topic_lo = 8'h00;
        st_topic = 16'h0000;
        st_count = 16'h0000;
        st_sum = 8'h00;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_frames(450);
        test_noise_and_broken(150);
        test_backpressure(80);
        test_burst(100);

        drain();
        $display("covered %0d parsed bytes: %0d payload items, %0d good frames,", bytes_parsed,
                 seen_payload, seen_good);
        $display("%0d length checksum errors, %0d message checksum errors, %0d mismatches",
                 seen_len_err, seen_msg_err, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("serial_frame_deframer_test: PASS");
        else
            $display("serial_frame_deframer_test: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_parser.sv
rtl/core/sfd_out_reg.sv
rtl/core/serial_frame_deframer.sv
verif/serial_frame_deframer_test.sv
